>>> hdl/tel_pkg.sv
// Shared types and constants for the throttled event log ring.
// Used by the controller, the datapath, the top level and the port checker.
// No dependencies.
package tel_pkg;

  localparam int unsigned RingDepthDef     = 16;
  localparam int unsigned ThrottleSlotsDef = 8;
  localparam int unsigned MaxResults       = 16;
  localparam int unsigned CntW             = 7;
  localparam int unsigned RecW             = 64;
  localparam int unsigned KeyW             = 32;
  localparam int unsigned TimeW            = 32;

  typedef enum logic [1:0] {
    MODE_LOG   = 2'd0,
    MODE_TLOG  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  // Record layout in the ring memory.
  typedef struct packed {
    logic [7:0]       arg_c;
    logic [7:0]       arg_b;
    logic [7:0]       arg_a;
    logic [7:0]       evt;
    logic [TimeW-1:0] stamp;
  } rec_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic append;
    logic tl_step;
    logic tl_commit;
    logic clear;
    logic rd_setup;
    logic rd_issue;
    logic push_op;
    logic push_rec;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic scan_last;
    logic cnt_zero;
    logic last_rec;
  } dp_status_t;

endpackage

>>> hdl/tel_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tel_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hdl/tel_datapath.sv
// Datapath of the event log ring: input capture, throttle table and its scan,
// ring pointers, read sequencing and the output register.
// Depends on tel_pkg and tel_ram.
module tel_datapath #(
  parameter int unsigned RingDepth     = tel_pkg::RingDepthDef,
  parameter int unsigned ThrottleSlots = tel_pkg::ThrottleSlotsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tel_pkg::ctl_cmd_t     cmd_i,
  output tel_pkg::dp_status_t   status_o,
  input  logic [7:0]            event_code_i,
  input  logic [7:0]            arg_a_i,
  input  logic [7:0]            arg_b_i,
  input  logic [7:0]            arg_c_i,
  input  logic [31:0]           now_ms_i,
  input  logic [31:0]           min_gap_ms_i,
  input  logic [7:0]            read_count_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic                  accepted_o,
  output logic                  found_o,
  output logic [31:0]           rec_time_o,
  output logic [7:0]            rec_event_o,
  output logic [7:0]            rec_arg_a_o,
  output logic [7:0]            rec_arg_b_o,
  output logic [7:0]            rec_arg_c_o,
  output logic [6:0]            returned_total_o,
  output logic [15:0]           wrap_total_o,
  output logic                  last_o
);
  import tel_pkg::*;

  localparam int unsigned PtrW  = $clog2(RingDepth);
  localparam int unsigned SlotW = (ThrottleSlots > 1) ? $clog2(ThrottleSlots) : 1;
  localparam int unsigned SumW  = CntW + 1;

  // Captured input item.
  logic [KeyW-1:0]  key_q;
  logic [TimeW-1:0] now_q;
  logic [TimeW-1:0] gap_q;
  logic [7:0]       want_q;

  // Ring pointers.
  logic [PtrW-1:0] wp_q, wp_d;
  logic [15:0]     wrap_q, wrap_d;

  // Throttle table.
  logic [KeyW-1:0]          tkey_q  [ThrottleSlots];
  logic [TimeW-1:0]         ttime_q [ThrottleSlots];
  logic [ThrottleSlots-1:0] tvalid_q;

  // Scan state.
  logic [SlotW-1:0] scan_idx_q;
  logic             match_q, mrej_q, free_q;
  logic [SlotW-1:0] midx_q, fidx_q, oidx_q;
  logic [TimeW-1:0] oldest_q;

  // Read sequencing.
  logic [PtrW-1:0] rd_idx_q;
  logic [CntW-1:0] cnt_q, rem_q;

  logic acc_q;

  logic             out_valid_q;
  logic             out_free;
  logic [KeyW-1:0]  ent_key;
  logic [TimeW-1:0] ent_time, ent_age;
  logic             ent_valid;
  logic [SlotW-1:0] victim;
  logic             do_append;
  rec_t             wr_rec, rd_rec;
  logic [RecW-1:0]  rd_data;
  logic [CntW-1:0]  avail, min1, cnt_new;
  logic [SumW-1:0]  start_sum, start_adj;
  logic [PtrW-1:0]  rd_idx_next;

  assign ent_key   = tkey_q[scan_idx_q];
  assign ent_time  = ttime_q[scan_idx_q];
  assign ent_valid = tvalid_q[scan_idx_q];
  assign ent_age   = now_q - ent_time;

  assign victim    = match_q ? midx_q : (free_q ? fidx_q : oidx_q);
  assign do_append = cmd_i.append | (cmd_i.tl_commit & ~(match_q & mrej_q));

  assign wr_rec = '{arg_c: key_q[31:24], arg_b: key_q[23:16], arg_a: key_q[15:8],
                    evt: key_q[7:0], stamp: now_q};

  always_comb begin
    if (wp_q == PtrW'(RingDepth - 1)) begin
      wp_d   = '0;
      wrap_d = wrap_q + 16'd1;
    end else begin
      wp_d   = wp_q + PtrW'(1);
      wrap_d = wrap_q;
    end
  end

  // Count of records for a read, and the index of the oldest one to return.
  always_comb begin
    avail     = (wrap_q != 16'd0) ? CntW'(RingDepth) : CntW'(wp_q);
    min1      = ({1'b0, avail} < want_q) ? avail : want_q[CntW-1:0];
    cnt_new   = (min1 > CntW'(MaxResults)) ? CntW'(MaxResults) : min1;
    start_sum = SumW'(wp_q) + SumW'(RingDepth) - SumW'(cnt_new);
    start_adj = (start_sum >= SumW'(RingDepth)) ? (start_sum - SumW'(RingDepth))
                                                : start_sum;
  end

  assign rd_idx_next = (rd_idx_q == PtrW'(RingDepth - 1)) ? '0 : (rd_idx_q + PtrW'(1));

  assign out_free = ~out_valid_q | ~out_stall_i;

  assign status_o = '{out_free:  out_free,
                      scan_last: (scan_idx_q == SlotW'(ThrottleSlots - 1)),
                      cnt_zero:  (cnt_q == '0),
                      last_rec:  (rem_q == CntW'(1))};

  // Input capture and read setup.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      key_q  <= {arg_c_i, arg_b_i, arg_a_i, event_code_i};
      now_q  <= now_ms_i;
      gap_q  <= min_gap_ms_i;
      want_q <= read_count_i;
    end
    if (cmd_i.rd_setup) begin
      cnt_q    <= cnt_new;
      rem_q    <= cnt_new;
      rd_idx_q <= PtrW'(start_adj);
    end else begin
      if (cmd_i.rd_issue) begin
        rd_idx_q <= rd_idx_next;
      end
      if (cmd_i.push_rec) begin
        rem_q <= rem_q - CntW'(1);
      end
    end
  end

  // Scan bookkeeping: first match, first free slot and oldest slot.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      scan_idx_q <= '0;
      match_q    <= 1'b0;
      mrej_q     <= 1'b0;
      free_q     <= 1'b0;
      oldest_q   <= '0;
      midx_q     <= '0;
      fidx_q     <= '0;
      oidx_q     <= '0;
    end else if (cmd_i.tl_step) begin
      scan_idx_q <= scan_idx_q + SlotW'(1);
      if (ent_valid && (ent_key == key_q) && !match_q) begin
        match_q <= 1'b1;
        midx_q  <= scan_idx_q;
        mrej_q  <= (ent_age < gap_q);
      end
      if (!ent_valid && !free_q) begin
        free_q <= 1'b1;
        fidx_q <= scan_idx_q;
      end
      if (ent_valid && (ent_age >= oldest_q)) begin
        oldest_q <= ent_age;
        oidx_q   <= scan_idx_q;
      end
    end
  end

  // Throttle table contents.
  always_ff @(posedge clk_i) begin
    if (cmd_i.tl_commit && !(match_q && mrej_q)) begin
      tkey_q[victim]  <= key_q;
      ttime_q[victim] <= now_q;
    end
  end

  // Control state of the datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q    <= '0;
      wp_q        <= '0;
      wrap_q      <= '0;
      acc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        tvalid_q <= '0;
        wp_q     <= '0;
        wrap_q   <= '0;
      end else begin
        if (cmd_i.tl_commit && !(match_q && mrej_q)) begin
          tvalid_q[victim] <= 1'b1;
        end
        if (do_append) begin
          wp_q   <= wp_d;
          wrap_q <= wrap_d;
        end
      end
      if (cmd_i.load_in) begin
        acc_q <= 1'b0;
      end else if (do_append) begin
        acc_q <= 1'b1;
      end
      if (cmd_i.push_op || cmd_i.push_rec) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  tel_ram #(
    .Width (RecW),
    .Depth (RingDepth)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (do_append),
    .wr_addr_i (wp_q),
    .wr_data_i (wr_rec),
    .rd_en_i   (cmd_i.rd_issue),
    .rd_addr_i (rd_idx_q),
    .rd_data_o (rd_data)
  );

  assign rd_rec = rd_data;

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_rec) begin
      accepted_o       <= 1'b0;
      found_o          <= 1'b1;
      rec_time_o       <= rd_rec.stamp;
      rec_event_o      <= rd_rec.evt;
      rec_arg_a_o      <= rd_rec.arg_a;
      rec_arg_b_o      <= rd_rec.arg_b;
      rec_arg_c_o      <= rd_rec.arg_c;
      returned_total_o <= cnt_q;
      wrap_total_o     <= wrap_q;
      last_o           <= (rem_q == CntW'(1));
    end else if (cmd_i.push_op) begin
      accepted_o       <= acc_q;
      found_o          <= 1'b0;
      rec_time_o       <= '0;
      rec_event_o      <= '0;
      rec_arg_a_o      <= '0;
      rec_arg_b_o      <= '0;
      rec_arg_c_o      <= '0;
      returned_total_o <= '0;
      wrap_total_o     <= wrap_q;
      last_o           <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/tel_ctrl.sv
// Controller state machine of the event log ring.
// Depends on tel_pkg; drives the datapath through ctl_cmd_t.
module tel_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          mode_i,
  input  tel_pkg::dp_status_t status_i,
  output tel_pkg::ctl_cmd_t   cmd_o
);
  import tel_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_LOG     = 9'b000000010,
    S_SCAN    = 9'b000000100,
    S_TCOMMIT = 9'b000001000,
    S_CLEAR   = 9'b000010000,
    S_RSETUP  = 9'b000100000,
    S_RADDR   = 9'b001000000,
    S_RPUSH   = 9'b010000000,
    S_PUSH    = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  mode_e  mode;

  assign mode       = mode_e'(mode_i);
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          unique case (mode)
            MODE_LOG:   state_d = S_LOG;
            MODE_TLOG:  state_d = S_SCAN;
            MODE_CLEAR: state_d = S_CLEAR;
            MODE_READ:  state_d = S_RSETUP;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_LOG: begin
        cmd_o.append = 1'b1;
        state_d      = S_PUSH;
      end
      S_SCAN: begin
        cmd_o.tl_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = S_TCOMMIT;
        end
      end
      S_TCOMMIT: begin
        cmd_o.tl_commit = 1'b1;
        state_d         = S_PUSH;
      end
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        state_d     = S_PUSH;
      end
      S_RSETUP: begin
        cmd_o.rd_setup = 1'b1;
        state_d        = S_RADDR;
      end
      S_RADDR: begin
        if (status_i.cnt_zero) begin
          state_d = S_PUSH;
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_d        = S_RPUSH;
        end
      end
      S_RPUSH: begin
        if (status_i.out_free) begin
          cmd_o.push_rec = 1'b1;
          state_d        = status_i.last_rec ? S_IDLE : S_RADDR;
        end
      end
      S_PUSH: begin
        if (status_i.out_free) begin
          cmd_o.push_op = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/throttled_event_log_ring.sv
// Top level of the throttled event log ring: controller plus datapath.
// Depends on tel_pkg, tel_ctrl, tel_datapath and tel_ram.
//
// The block keeps a ring of RingDepth timestamped event records and a throttle
// table of ThrottleSlots entries, and takes one operation per input transfer:
// log, throttled log, clear, or read the newest records. It works on one item
// at a time. A log or a clear goes through one working state and then offers
// its result. A throttled log first scans the throttle table one entry per
// cycle to find the first matching entry, the first free entry and the oldest
// entry, then commits and offers its result. A read has a setup state and then
// an address state and a push state per record returned, set by the registered
// read port of the ring memory; a read that returns nothing offers its single
// result after the setup. The input stays stalled until the last result of the
// item has moved into the output register, and the next input transfer can
// follow in the cycle after that. A result held by out_stall_i also holds back
// the result behind it. The result sits in an output register, so a new input
// transfer is taken while a finished result still waits on out_stall_i. The
// ring memory is not cleared on reset or on a clear operation: only entries
// that were written since then can ever be read, so the pointers alone carry
// the cleared state, and no clearing pass is needed.
module throttled_event_log_ring #(
  parameter int unsigned RingDepth     = tel_pkg::RingDepthDef,
  parameter int unsigned ThrottleSlots = tel_pkg::ThrottleSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  event_code_i,
  input  logic [7:0]  arg_a_i,
  input  logic [7:0]  arg_b_i,
  input  logic [7:0]  arg_c_i,
  input  logic [31:0] now_ms_i,
  input  logic [31:0] min_gap_ms_i,
  input  logic [7:0]  read_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic        found_o,
  output logic [31:0] rec_time_o,
  output logic [7:0]  rec_event_o,
  output logic [7:0]  rec_arg_a_o,
  output logic [7:0]  rec_arg_b_o,
  output logic [7:0]  rec_arg_c_o,
  output logic [6:0]  returned_total_o,
  output logic [15:0] wrap_total_o,
  output logic        last_o
);
  import tel_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  // The controller sequences each operation; of the input item it sees only the mode field.
  tel_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds all storage and the output register.
  tel_datapath #(
    .RingDepth     (RingDepth),
    .ThrottleSlots (ThrottleSlots)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .event_code_i     (event_code_i),
    .arg_a_i          (arg_a_i),
    .arg_b_i          (arg_b_i),
    .arg_c_i          (arg_c_i),
    .now_ms_i         (now_ms_i),
    .min_gap_ms_i     (min_gap_ms_i),
    .read_count_i     (read_count_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .accepted_o       (accepted_o),
    .found_o          (found_o),
    .rec_time_o       (rec_time_o),
    .rec_event_o      (rec_event_o),
    .rec_arg_a_o      (rec_arg_a_o),
    .rec_arg_b_o      (rec_arg_b_o),
    .rec_arg_c_o      (rec_arg_c_o),
    .returned_total_o (returned_total_o),
    .wrap_total_o     (wrap_total_o),
    .last_o           (last_o)
  );

endmodule

>>> hdl/tel_checker.sv
// Port-level checker for the throttled event log ring, bound to the top level.
// Depends on tel_pkg.
module tel_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        accepted_o,
  input logic        found_o,
  input logic [31:0] rec_time_o,
  input logic [6:0]  returned_total_o,
  input logic        last_o
);
  import tel_pkg::*;

  // A result held back by the consumer stays offered, its time stamp and last flag unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(rec_time_o) && $stable(last_o))
    else $error("stalled result changed");

  // One item at a time: the cycle after an input transfer the input is stalled.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in progress");

  // A record from a read never reports a logged event and carries a count.
  a_rec_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> !accepted_o && (returned_total_o != 7'd0) &&
                               (returned_total_o <= 7'(MaxResults)))
    else $error("bad record result");

  // A result without a record is the only result of its item.
  a_norec_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> last_o && (returned_total_o == 7'd0))
    else $error("bad non-record result");

endmodule

bind throttled_event_log_ring tel_checker u_tel_checker (.*);
